FILE: rtl/bls_pkg.sv
// shared types, codes and the microcode table of the bounded list store
// depends on nothing; imported by bounded_list_store

package bls_pkg;

	localparam int WORD_W    = 64;
	localparam int OP_W      = 3;
	localparam int STATUS_W  = 2;
	localparam int DEPTH_DEF = 16;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND     = 3'd0,
		OP_PREPEND    = 3'd1,
		OP_READ_AT    = 3'd2,
		OP_READ_FIRST = 3'd3,
		OP_READ_LAST  = 3'd4,
		OP_FIND       = 3'd5
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	// microcode step addresses
	typedef enum logic [4:0] {
		U_FETCH, U_APP, U_APP_WR, U_PRE, U_PRE_RD, U_PRE_SH, U_PRE_FIN,
		U_RAT, U_RFIRST, U_RLAST, U_RD_CAP, U_FIND, U_F_RD, U_F_CMP,
		U_F_HIT, U_FULL, U_RANGE, U_OUT
	} upc_t;

	typedef enum logic [2:0] {
		C_NEVER, C_FULL, C_EMPTY, C_IDX_OOR, C_PTR_ZERO, C_MATCH, C_SCAN_END,
		C_OUT_BUSY
	} cond_t;

	typedef enum logic [2:0] {
		RA_PTR, RA_PTR_UP, RA_PTR_DN, RA_IDX, RA_ZERO, RA_LAST
	} ra_sel_t;

	typedef enum logic [1:0] {
		WA_CNT, WA_PTR_UP, WA_ZERO
	} wa_sel_t;

	typedef enum logic {
		WD_VAL, WD_RD
	} wd_sel_t;

	typedef enum logic [2:0] {
		PTR_HOLD, PTR_ZERO, PTR_LAST, PTR_INC, PTR_DEC
	} ptr_op_t;

	typedef enum logic [2:0] {
		RES_NONE, RES_FULL, RES_RANGE, RES_DATA, RES_POS_PREV
	} res_t;

	// datapath conditions seen by the sequencer
	typedef struct packed {
		logic full;
		logic empty;
		logic idx_oor;
		logic ptr_zero;
		logic match;
		logic scan_end;
		logic out_busy;
	} flags_t;

	// one control word
	typedef struct packed {
		logic    disp;
		logic    emit;
		ra_sel_t ra;
		logic    we;
		wa_sel_t wa;
		wd_sel_t wd;
		ptr_op_t ptr_op;
		logic    cnt_inc;
		res_t    res;
		cond_t   cond_a;
		upc_t    tgt_a;
		cond_t   cond_b;
		upc_t    tgt_b;
		upc_t    tgt_else;
	} ctrl_t;

	// entry step of each request
	function automatic upc_t op_entry(logic [OP_W-1:0] op);
		upc_t e;
		unique case (op)
			OP_APPEND:     e = U_APP;
			OP_PREPEND:    e = U_PRE;
			OP_READ_AT:    e = U_RAT;
			OP_READ_FIRST: e = U_RFIRST;
			OP_READ_LAST:  e = U_RLAST;
			OP_FIND:       e = U_FIND;
			default:       e = U_RANGE;
		endcase
		return e;
	endfunction

	// microprogram
	function automatic ctrl_t ucode_rom(upc_t upc);
		ctrl_t w;
		w = '0;
		w.tgt_a    = U_FETCH;
		w.tgt_b    = U_FETCH;
		w.tgt_else = U_OUT;
		unique case (upc)
			U_FETCH: begin
				w.disp = 1'b1;
			end
			U_APP: begin
				w.cond_a = C_FULL;   w.tgt_a = U_FULL;
				w.tgt_else = U_APP_WR;
			end
			U_APP_WR: begin
				w.we = 1'b1; w.wa = WA_CNT; w.wd = WD_VAL; w.cnt_inc = 1'b1;
			end
			U_PRE: begin
				w.ptr_op = PTR_LAST;
				w.cond_a = C_FULL;   w.tgt_a = U_FULL;
				w.cond_b = C_EMPTY;  w.tgt_b = U_PRE_FIN;
				w.tgt_else = U_PRE_RD;
			end
			U_PRE_RD: begin
				w.ra = RA_PTR;
				w.tgt_else = U_PRE_SH;
			end
			U_PRE_SH: begin
				w.we = 1'b1; w.wa = WA_PTR_UP; w.wd = WD_RD;
				w.ra = RA_PTR_DN; w.ptr_op = PTR_DEC;
				w.cond_a = C_PTR_ZERO; w.tgt_a = U_PRE_FIN;
				w.tgt_else = U_PRE_SH;
			end
			U_PRE_FIN: begin
				w.we = 1'b1; w.wa = WA_ZERO; w.wd = WD_VAL; w.cnt_inc = 1'b1;
			end
			U_RAT: begin
				w.ra = RA_IDX;
				w.cond_a = C_IDX_OOR; w.tgt_a = U_RANGE;
				w.tgt_else = U_RD_CAP;
			end
			U_RFIRST: begin
				w.ra = RA_ZERO;
				w.cond_a = C_EMPTY;  w.tgt_a = U_RANGE;
				w.tgt_else = U_RD_CAP;
			end
			U_RLAST: begin
				w.ra = RA_LAST;
				w.cond_a = C_EMPTY;  w.tgt_a = U_RANGE;
				w.tgt_else = U_RD_CAP;
			end
			U_RD_CAP: begin
				w.res = RES_DATA;
			end
			U_FIND: begin
				w.ptr_op = PTR_ZERO;
				w.cond_a = C_EMPTY;  w.tgt_a = U_OUT;
				w.tgt_else = U_F_RD;
			end
			U_F_RD: begin
				w.ra = RA_PTR;
				w.tgt_else = U_F_CMP;
			end
			U_F_CMP: begin
				w.ra = RA_PTR_UP; w.ptr_op = PTR_INC;
				w.cond_a = C_MATCH;    w.tgt_a = U_F_HIT;
				w.cond_b = C_SCAN_END; w.tgt_b = U_OUT;
				w.tgt_else = U_F_CMP;
			end
			U_F_HIT: begin
				w.res = RES_POS_PREV;
			end
			U_FULL: begin
				w.res = RES_FULL;
			end
			U_RANGE: begin
				w.res = RES_RANGE;
			end
			U_OUT: begin
				w.emit = 1'b1;
				w.cond_a = C_OUT_BUSY; w.tgt_a = U_OUT;
				w.tgt_else = U_FETCH;
			end
			default: begin
				w.tgt_else = U_FETCH;
			end
		endcase
		return w;
	endfunction

endpackage

FILE: rtl/bls_ram.sv
// generic simple dual-port ram: one write port, one read port, registered read
// depends on nothing

module bls_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/bounded_list_store.sv
// bounded list store: append, prepend, reads and find each return one result, as do
// full or range errors; an unknown op returns a range error and a find on an empty
// list returns no match; the next request is taken only after the result is loaded,
// one request at a time
// prepend moves and find compares one entry per cycle through the single ram read port;
// async reset clears count, sequencer and output valid, entry storage is not cleared

module bounded_list_store #(
	parameter int DEPTH = bls_pkg::DEPTH_DEF,
	localparam int IDX_W = $clog2(DEPTH),
	localparam int CNT_W = $clog2(DEPTH + 1),
	localparam int POS_W = IDX_W + 1,
	localparam int S_TDATA_W = ((bls_pkg::WORD_W + IDX_W + 7) / 8) * 8,
	localparam int M_TDATA_W =
		((bls_pkg::WORD_W + POS_W + bls_pkg::STATUS_W + CNT_W + 7) / 8) * 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// request stream
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [S_TDATA_W-1:0]     s_tdata,  // value, index, zero pad
	input  logic [bls_pkg::OP_W-1:0] s_tuser,  // op
	// result stream
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [M_TDATA_W-1:0]     m_tdata   // data, position, status, count, zero pad
);

	import bls_pkg::*;

	// sequencer
	upc_t   upc_q, upc_d;
	ctrl_t  ctrl;
	flags_t flg;
	logic   s_xfer;
	logic   emit_load;

	// datapath registers
	logic [WORD_W-1:0] val_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  ptr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  cnt_m1;
	logic [WORD_W-1:0] data_q;
	logic [POS_W-1:0]  pos_q;
	status_t           status_q;
	logic              m_tvalid_q;
	logic [M_TDATA_W-1:0] out_q;

	// entry ram ports
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic [IDX_W-1:0]  ram_raddr;
	logic [WORD_W-1:0] ram_rdata;

	function automatic logic cond_eval(cond_t c, flags_t f);
		logic r;
		unique case (c)
			C_NEVER:    r = 1'b0;
			C_FULL:     r = f.full;
			C_EMPTY:    r = f.empty;
			C_IDX_OOR:  r = f.idx_oor;
			C_PTR_ZERO: r = f.ptr_zero;
			C_MATCH:    r = f.match;
			C_SCAN_END: r = f.scan_end;
			C_OUT_BUSY: r = f.out_busy;
			default:    r = 1'b0;
		endcase
		return r;
	endfunction

	// control word for the current step
	assign ctrl = ucode_rom(upc_q);

	assign s_tready  = ctrl.disp;
	assign s_xfer    = s_tvalid & s_tready;
	assign cnt_m1    = cnt_q - CNT_W'(1);

	// condition flags from the datapath
	assign flg.full     = (cnt_q == CNT_W'(DEPTH));
	assign flg.empty    = (cnt_q == '0);
	assign flg.idx_oor  = (CNT_W'(idx_q) >= cnt_q);
	assign flg.ptr_zero = (ptr_q == '0);
	assign flg.match    = (ram_rdata == val_q);
	assign flg.scan_end = ((CNT_W'(ptr_q) + CNT_W'(1)) == cnt_q);
	assign flg.out_busy = m_tvalid_q & ~m_tready;

	// result register loads when the output slot is free or draining
	assign emit_load = ctrl.emit & ~flg.out_busy;

	// next step: dispatch on op in fetch, else two conditional jumps and a fallthrough
	always_comb begin
		if (ctrl.disp) begin
			upc_d = s_xfer ? op_entry(s_tuser) : U_FETCH;
		end else if (cond_eval(ctrl.cond_a, flg)) begin
			upc_d = ctrl.tgt_a;
		end else if (cond_eval(ctrl.cond_b, flg)) begin
			upc_d = ctrl.tgt_b;
		end else begin
			upc_d = ctrl.tgt_else;
		end
	end

	// ram read address
	always_comb begin
		unique case (ctrl.ra)
			RA_PTR:    ram_raddr = ptr_q;
			RA_PTR_UP: ram_raddr = ptr_q + IDX_W'(1);
			RA_PTR_DN: ram_raddr = ptr_q - IDX_W'(1);
			RA_IDX:    ram_raddr = idx_q;
			RA_ZERO:   ram_raddr = '0;
			RA_LAST:   ram_raddr = cnt_m1[IDX_W-1:0];
			default:   ram_raddr = ptr_q;
		endcase
	end

	// ram write address and data
	always_comb begin
		ram_we = ctrl.we;
		unique case (ctrl.wa)
			WA_CNT:    ram_waddr = cnt_q[IDX_W-1:0];
			WA_PTR_UP: ram_waddr = ptr_q + IDX_W'(1);
			WA_ZERO:   ram_waddr = '0;
			default:   ram_waddr = '0;
		endcase
		ram_wdata = (ctrl.wd == WD_RD) ? ram_rdata : val_q;
	end

	bls_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH)
	) u_entries (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// control state: step counter, entry count, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q      <= U_FETCH;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			upc_q <= upc_d;
			if (ctrl.cnt_inc) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (emit_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload: request latch, scan pointer, result fields, output register
	always_ff @(posedge clk) begin
		if (s_xfer) begin
			val_q    <= s_tdata[WORD_W-1:0];
			idx_q    <= s_tdata[WORD_W +: IDX_W];
			data_q   <= '0;
			pos_q    <= '1;  // no match
			status_q <= ST_OK;
		end else begin
			unique case (ctrl.res)
				RES_NONE:     ;
				RES_FULL:     status_q <= ST_FULL;
				RES_RANGE:    status_q <= ST_RANGE;
				RES_DATA:     data_q   <= ram_rdata;
				// pointer already stepped past the matching entry
				RES_POS_PREV: pos_q    <= {1'b0, ptr_q - IDX_W'(1)};
				default:      ;
			endcase
		end

		unique case (ctrl.ptr_op)
			PTR_HOLD: ;
			PTR_ZERO: ptr_q <= '0;
			PTR_LAST: ptr_q <= cnt_m1[IDX_W-1:0];
			PTR_INC:  ptr_q <= ptr_q + IDX_W'(1);
			PTR_DEC:  ptr_q <= ptr_q - IDX_W'(1);
			default:  ;
		endcase

		if (emit_load) begin
			out_q <= M_TDATA_W'({cnt_q, status_q, pos_q, data_q});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_q;

	// count never passes capacity
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("entry count above capacity");

	// a full status is only reported on a full list
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_load && status_q == ST_FULL) |-> flg.full)
		else $error("full status with free entries");

	// sequencer leaves fetch only on a request transfer
	a_fetch_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(upc_q == U_FETCH && !s_xfer) |=> (upc_q == U_FETCH))
		else $error("sequencer left fetch without a request");

	// the count moves only by one per step
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		!ctrl.cnt_inc |=> (cnt_q == $past(cnt_q)))
		else $error("entry count changed without an insert");

endmodule
